@@ rtl/core/apr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_pkg
// Shared constants for the accumulated pixel resolve block.
// ----------------------------------------------------------------------------
package apr_pkg;

  // Default datapath shape
  localparam int unsigned AprSumWidth = 32;
  localparam int unsigned AprFracBits = 16;

  // Sample count register
  localparam int unsigned AprCntW   = 16;
  localparam int unsigned AprDataW  = 32;
  localparam int unsigned AprAddrW  = 3;

  // Register index, taken from paddr[2]
  localparam logic AprRegSampleCount = 1'b0;

  // Constant alpha byte of the packed word
  localparam logic [7:0] AprAlpha = 8'hFF;

endpackage

@@ rtl/core/accumulated_pixel_resolve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulated_pixel_resolve
// Resolves one accumulated pixel per clock while no result is stalled: mean over the sample count,
// gamma 2 by square root, scale to bytes, pack as ARGB.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, *_sum_i           | request in
//  out     | out_valid_o, out_stall_i, pixel_word_o    | request out
//  cfg     | psel, penable, pwrite, paddr, pwdata ...  | register port
//
// One request per cycle while no result is stalled; the pipeline has
// one divide stage and one root stage per result bit.
// Reset clears the valid bits and sets sample_count to 1.
// An output stall on a valid result freezes the whole pipeline; in_stall_o follows it.
// ----------------------------------------------------------------------------
module accumulated_pixel_resolve #(
  parameter int unsigned SUM_WIDTH = apr_pkg::AprSumWidth,
  parameter int unsigned FRAC_BITS = apr_pkg::AprFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [SUM_WIDTH-1:0]         red_sum_i,
  input  logic [SUM_WIDTH-1:0]         green_sum_i,
  input  logic [SUM_WIDTH-1:0]         blue_sum_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  pixel_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apr_pkg::AprAddrW-1:0] paddr,
  input  logic [apr_pkg::AprDataW-1:0] pwdata,
  output logic [apr_pkg::AprDataW-1:0] prdata,
  output logic                         pready
);
  import apr_pkg::*;

  localparam int unsigned Lat = 2 * FRAC_BITS + 4;

  // ---------------- register port
  logic [AprCntW-1:0] cnt_q;
  logic               wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == AprRegSampleCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= AprCntW'(1);
    end else if (wr_en) begin
      cnt_q <= pwdata[AprCntW-1:0];
    end
  end

  assign prdata = (paddr[2] == AprRegSampleCount) ? AprDataW'(cnt_q) : '0;

  // Zero count acts as one
  logic [AprCntW-1:0] div;
  assign div = (cnt_q == '0) ? AprCntW'(1) : cnt_q;

  // ---------------- valid pipeline, global advance
  logic [Lat-1:0] vld_q;
  logic           en;
  assign en = !(vld_q[Lat-1] && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Lat-1];

  // ---------------- color lanes
  logic [7:0] red_b, green_b, blue_b;

  apr_channel #(.SUM_WIDTH(SUM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_red (
    .clk_i, .en_i(en), .sum_i(red_sum_i), .div_i(div), .byte_o(red_b)
  );
  apr_channel #(.SUM_WIDTH(SUM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_green (
    .clk_i, .en_i(en), .sum_i(green_sum_i), .div_i(div), .byte_o(green_b)
  );
  apr_channel #(.SUM_WIDTH(SUM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_blue (
    .clk_i, .en_i(en), .sum_i(blue_sum_i), .div_i(div), .byte_o(blue_b)
  );

  assign pixel_word_o = {AprAlpha, red_b, green_b, blue_b};

  // ---------------- assertions
  a_stall_only_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_cnt_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (cnt_q == $past(pwdata[AprCntW-1:0])))
    else $error("sample count write lost");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(vld_q)))
    else $error("pipeline moved while the result was stalled");

endmodule

@@ rtl/core/apr_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_channel
// One color lane: pipelined restoring divide by the sample count with
// saturation at 1.0, pipelined bit-per-stage square root, scale to a byte.
// ----------------------------------------------------------------------------
module apr_channel #(
  parameter int unsigned SUM_WIDTH = apr_pkg::AprSumWidth,
  parameter int unsigned FRAC_BITS = apr_pkg::AprFracBits
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [SUM_WIDTH-1:0]         sum_i,
  input  logic [apr_pkg::AprCntW-1:0]  div_i,
  output logic [7:0]                   byte_o
);
  import apr_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned DW   = AprCntW;
  localparam int unsigned RW   = DW + 1;          // divide remainder
  localparam int unsigned EW   = SUM_WIDTH + DW + F + 2;
  localparam int unsigned R    = F + 1;           // root bits
  localparam int unsigned VW   = 2 * R;           // radicand bits
  localparam int unsigned SRW  = R + 3;           // root remainder
  localparam logic [R-1:0] One = R'(1) << F;

  // ---------------- stage 0: operand split and saturation check
  logic [EW-1:0] ext;
  logic [EW-1:0] thresh;
  assign ext    = EW'(sum_i);
  assign thresh = (EW'(div_i) << F) + EW'(div_i);

  logic [RW-1:0] rem_q [0:F+1];
  logic [F:0]    qs_q  [0:F+1];
  logic          sat_q [0:F+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ext[F+1 +: RW];
      qs_q[0]  <= ext[F:0];
      sat_q[0] <= (ext >= thresh);
    end
  end

  // ---------------- divide: one quotient bit per stage
  for (genvar k = 1; k <= F + 1; k++) begin : g_div
    logic [RW-1:0] t;
    logic          ge;
    assign t  = {rem_q[k-1][RW-2:0], qs_q[k-1][F]};
    assign ge = (t >= RW'(div_i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (t - RW'(div_i)) : t;
        qs_q[k]  <= {qs_q[k-1][F-1:0], ge};
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  // Mean, held at 1.0
  logic [R-1:0] mean;
  assign mean = sat_q[F+1] ? One : qs_q[F+1];

  // ---------------- square root: one root bit per stage
  logic [SRW-1:0] sr_q [0:R];
  logic [R-1:0]   rt_q [0:R];
  logic [VW-1:0]  vs_q [0:R];

  assign sr_q[0] = '0;
  assign rt_q[0] = '0;
  assign vs_q[0] = VW'({mean, {F{1'b0}}});

  for (genvar j = 1; j <= R; j++) begin : g_sqrt
    logic [SRW-1:0] t;
    logic [SRW-1:0] trial;
    logic           ge;
    assign t     = {sr_q[j-1][SRW-3:0], vs_q[j-1][VW-1 -: 2]};
    assign trial = SRW'({rt_q[j-1], 2'b01});
    assign ge    = (t >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[j] <= ge ? (t - trial) : t;
        rt_q[j] <= {rt_q[j-1][R-2:0], ge};
        vs_q[j] <= {vs_q[j-1][VW-3:0], 2'b00};
      end
    end
  end

  // ---------------- clamp, times 255, truncate to a byte
  logic [R-1:0]   rc;
  logic [R+7:0]   prod;
  logic [7:0]     byte_q;
  assign rc   = (rt_q[R] > One) ? One : rt_q[R];
  assign prod = {rc, 8'h00} - (R+8)'(rc);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= prod[F +: 8];
    end
  end

  assign byte_o = byte_q;

endmodule
